### hw/rtl/nrcr_pkg.sv
// Package for the Newton-Raphson cubic root unit.
// Holds widths, the outcome and config index codes and the sequencer state type. No dependencies.
`default_nettype none
package nrcr_pkg;

    localparam int TOL_W  = 24;
    localparam int ITER_W = 8;
    localparam int OUT_W  = 32;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [1:0] {
        OC_CONVERGED = 2'd0,
        OC_LIMIT     = 2'd1,
        OC_ZERO_DER  = 2'd2
    } t_outcome;

    typedef enum logic [0:0] {
        CFG_TOLERANCE = 1'b0,
        CFG_MAX_ITER  = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_X2,
        ST_MUL_X3,
        ST_FUNC,
        ST_DERIV,
        ST_DIV_SETUP,
        ST_DIV,
        ST_UPDATE,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

### hw/rtl/newton_raphson_cubic_root_unit.sv
// Newton-Raphson root finder for f(x)=5x^3+3x^2-3, signed fixed point.
// Depends on nrcr_pkg. Checker lives in nrcr_checker.sv.
//
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    tdata[31:0] initial_guess
//  m_axis    out  m_axis_tvalid/tready    tdata[41:0] root, outcome, iterations
//  cfg       in   i_cfg_we                i_cfg_idx, i_cfg_data
//
// One iteration steps through check, the x^2 and x^3 multiplies, the function
// and derivative combines, divider setup, VALUE_WIDTH+FRACTION_BITS restoring
// divide steps and the update; the default format is Q16.16. A run also
// passes the accept state, a final check on the limit path and the result
// state. Synchronous active-low reset; no clearing pass.
// One item at a time: s_axis_tready is low from transfer in until the result is taken.
`default_nettype none
module newton_raphson_cubic_root_unit
    import nrcr_pkg::*;
#(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [31:0]           s_axis_tdata,   // [31:0] initial_guess
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [47:0]                m_axis_tdata,   // [31:0] root_value,
                                                       // [33:32] outcome,
                                                       // [41:34] iterations_used
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int W  = VALUE_WIDTH;
    localparam int FB = FRACTION_BITS;
    localparam int PW = 2 * W;               // magnitude product width
    localparam int NW = W + FB;              // shifted numerator width
    localparam int CW = $clog2(NW + 1);
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    t_state r_state, n_state;
    logic [TOL_W-1:0]  r_tol;
    logic [ITER_W-1:0] r_max_iter;
    logic signed [W-1:0] r_x, r_x2, r_x3, r_f, r_d;
    logic [ITER_W-1:0] r_k;
    t_outcome r_outcome;
    logic [NW-1:0] r_quo, r_num;
    logic [W:0]    r_rem;
    logic [W-1:0]  r_den;
    logic          r_qneg;
    logic [CW-1:0] r_cnt;
    logic [OUT_W-1:0] root_out;

    // ---------- saturating helpers ----------
    function automatic logic [W-1:0] sat_sgn(input logic neg, input logic [PW:0] mag);
        logic [W-1:0] res;
        begin
            if (neg) begin
                if (mag > {{(PW-W+1){1'b0}}, MINV}) res = MINV;
                else res = W'(-mag);
            end else begin
                if (mag > {{(PW-W+1){1'b0}}, MAXV}) res = MAXV;
                else res = mag[W-1:0];
            end
            return res;
        end
    endfunction

    function automatic logic [W-1:0] abs_v(input logic signed [W-1:0] v);
        return v[W-1] ? W'(-v) : v;
    endfunction

    function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        logic signed [W:0] s;
        begin
            s = {a[W-1], a} + {b[W-1], b};
            if (s[W] != s[W-1]) return s[W] ? MINV : MAXV;
            return s[W-1:0];
        end
    endfunction

    // ---------- shared multiplier ----------
    logic signed [W-1:0] mul_a, mul_b, mul_res;
    logic [PW-1:0] mul_full;
    always_comb begin
        mul_a = r_x;
        mul_b = r_x;
        if (r_state == ST_MUL_X3) begin
            mul_a = r_x2;
        end
        mul_full = PW'(abs_v(mul_a)) * PW'(abs_v(mul_b));
        mul_res  = sat_sgn(mul_a[W-1] ^ mul_b[W-1], (PW+1)'(mul_full >> FB));
    end

    // small constant multiply: exact then saturate
    function automatic logic signed [W-1:0] mulk(input logic signed [W-1:0] v,
                                                 input logic [3:0] k);
        logic [PW:0] m;
        begin
            m = (PW+1)'(abs_v(v)) * (PW+1)'(k);
            return sat_sgn(v[W-1], m);
        end
    endfunction

    logic signed [W-1:0] c_three;
    assign c_three = sat_sgn(1'b0, (PW+1)'(3) << FB);

    // ---------- divider step ----------
    logic [W:0]  div_trial;
    logic [W+1:0] div_shift;
    logic        div_take;
    always_comb begin
        div_shift = {r_rem, r_num[NW-1]};
        div_take  = div_shift >= {2'b00, r_den};
        div_trial = div_take ? (W+1)'(div_shift - {2'b00, r_den}) : div_shift[W:0];
    end

    // quotient saturation: highest bits overflow flag kept in r_quo path
    logic r_qhuge;
    logic signed [W-1:0] quo_sat, x1, x_in;
    logic [W:0] step;
    logic [32:0] in_mag;
    always_comb begin
        quo_sat = sat_sgn(r_qneg, (PW+1)'(r_quo) | ((PW+1)'(r_qhuge) << W));
        x1 = sadd(r_x, (quo_sat == MINV) ? MAXV : W'(-quo_sat));
        if (quo_sat == MINV && !r_x[W-1]) x1 = MAXV;
        else if (quo_sat == MINV) x1 = sadd(sadd(r_x, MAXV), W'(1));
        step = (x1 >= r_x) ? (W+1)'({x1[W-1], x1} - {r_x[W-1], r_x})
                           : (W+1)'({r_x[W-1], r_x} - {x1[W-1], x1});
        // guess magnitude from the full 32-bit input, then fit to the value width
        in_mag = s_axis_tdata[31] ? 33'd0 - {1'b1, s_axis_tdata} : {1'b0, s_axis_tdata};
        x_in = sat_sgn(s_axis_tdata[31], (PW+1)'(in_mag));
    end

    // ---------- next state ----------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:      if (s_axis_tvalid) n_state = ST_CHECK;
            ST_CHECK:     n_state = (r_k == r_max_iter) ? ST_DONE : ST_MUL_X2;
            ST_MUL_X2:    n_state = ST_MUL_X3;
            ST_MUL_X3:    n_state = ST_FUNC;
            ST_FUNC:      n_state = ST_DERIV;
            ST_DERIV:     n_state = ST_DIV_SETUP;
            ST_DIV_SETUP: n_state = (r_d == '0) ? ST_DONE : ST_DIV;
            ST_DIV:       if (r_cnt == CW'(NW - 1)) n_state = ST_UPDATE;
            ST_UPDATE:    n_state = (step < (W+1)'(r_tol)) ? ST_DONE : ST_CHECK;
            ST_DONE:      if (m_axis_tready) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // ---------- registers ----------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_tol      <= TOL_W'(66);
            r_max_iter <= ITER_W'(20);
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_TOLERANCE: r_tol      <= i_cfg_data;
                    CFG_MAX_ITER:  r_max_iter <= i_cfg_data[ITER_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_x       <= x_in;
                r_k       <= '0;
                r_outcome <= OC_LIMIT;
            end
            ST_MUL_X2: r_x2 <= mul_res;
            ST_MUL_X3: r_x3 <= mul_res;
            ST_FUNC:   r_f  <= sadd(sadd(mulk(r_x3, 4'd5), mulk(r_x2, 4'd3)),
                                    (c_three == MINV) ? MAXV : W'(-c_three));
            ST_DERIV:  r_d  <= sadd(mulk(r_x2, 4'd15), mulk(r_x, 4'd6));
            ST_DIV_SETUP: begin
                if (r_d == '0) r_outcome <= OC_ZERO_DER;
                r_num   <= NW'(abs_v(r_f)) << FB;
                r_den   <= abs_v(r_d);
                r_rem   <= '0;
                r_quo   <= '0;
                r_qhuge <= 1'b0;
                r_qneg  <= r_f[W-1] ^ r_d[W-1];
                r_cnt   <= '0;
            end
            ST_DIV: begin
                r_rem <= div_trial;
                r_num <= r_num << 1;
                // bits above the value width only flag overflow
                if (div_take && r_quo[NW-1:W-1] != '0) r_qhuge <= 1'b1;
                r_quo <= {r_quo[NW-2:0], div_take};
                r_cnt <= r_cnt + CW'(1);
            end
            ST_UPDATE: begin
                r_x <= x1;
                r_k <= r_k + ITER_W'(1);
                if (step < (W+1)'(r_tol)) r_outcome <= OC_CONVERGED;
            end
            default: ;
        endcase
    end

    always_comb begin
        if (W > OUT_W) begin
            if ($signed(r_x) > $signed(W'({1'b0, {(OUT_W-1){1'b1}}})))
                root_out = {1'b0, {(OUT_W-1){1'b1}}};
            else if ($signed(r_x) < -$signed(W'({1'b0, {(OUT_W-1){1'b1}}})) - 1)
                root_out = {1'b1, {(OUT_W-1){1'b0}}};
            else root_out = OUT_W'(r_x);
        end else begin
            root_out = OUT_W'(signed'(r_x));
        end
    end

    // ---------- outputs ----------
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        m_axis_tvalid = (r_state == ST_DONE);
        m_axis_tdata  = {6'd0, (r_outcome == OC_LIMIT) ? r_max_iter : r_k,
                         r_outcome, root_out};
    end

endmodule
`default_nettype wire

### hw/rtl/nrcr_checker.sv
// Port-level checker for the Newton-Raphson cubic root unit, bound to the top.
// Depends on nrcr_pkg.
`default_nettype none
module nrcr_checker
    import nrcr_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata
);
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed under stall");
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[33:32] != 2'd3) else $error("bad outcome");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("took two items");
endmodule

bind newton_raphson_cubic_root_unit nrcr_checker u_nrcr_checker (.*);
`default_nettype wire
